// ===== src/core_idle_load_monitor_defines.svh =====
// Assertion macros shared by the core idle load monitor RTL.
`ifndef CORE_IDLE_LOAD_MONITOR_DEFINES_SVH
`define CORE_IDLE_LOAD_MONITOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Plain property, sampled on clk, off while reset is asserted.
`define CILM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication: when ante holds, cons must hold in the same cycle.
`define CILM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define CILM_ASSERT(lbl, prop, msg)
`define CILM_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

// ===== src/cilm_pkg.sv =====
// Types, constants and control/status structs of the core idle load monitor.
`default_nettype none

package cilm_pkg;

	localparam int NUM_CORES_DEF = 2;
	localparam int NEST_BITS_DEF = 8;

	localparam int TS_W      = 32;
	localparam int PCT_W     = 7;
	localparam int PROD_W    = TS_W + PCT_W;
	localparam int DIV_STEPS = PCT_W;
	localparam int CNT_W     = 3;

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	localparam logic [1:0] ACT_IDLE  = 2'd0;
	localparam logic [1:0] ACT_BUSY  = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0]      action;
		logic            core;
		logic [TS_W-1:0] now_us;
	} req_item_t;

	typedef struct packed {
		logic [PCT_W-1:0] load_percent;
		logic             never_seen;
	} rsp_item_t;

	typedef struct packed {
		logic load_item;
		logic do_event;
		logic do_query;
		logic set_unseen;
		logic load_mul;
		logic div_step;
		logic load_out;
	} cilm_cmd_t;

	typedef struct packed {
		logic is_event;
		logic is_query;
		logic seen;
		logic elapsed_zero;
		logic div_last;
	} cilm_status_t;

endpackage

`default_nettype wire

// ===== src/cilm_dp.sv =====
// Datapath: per-core idle bookkeeping, query window, multiply and serial divide.
`default_nettype none
`include "core_idle_load_monitor_defines.svh"

module cilm_dp #(
	parameter int NUM_CORES = cilm_pkg::NUM_CORES_DEF,
	parameter int NEST_BITS = cilm_pkg::NEST_BITS_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  cilm_pkg::req_item_t    req,
	input  cilm_pkg::cilm_cmd_t    cmd,
	output cilm_pkg::cilm_status_t status,
	output cilm_pkg::rsp_item_t    rsp
);

	localparam int CORE_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
	localparam logic [NEST_BITS-1:0] NEST_MAX = '1;
	localparam logic [NEST_BITS-1:0] NEST_ONE = NEST_BITS'(1);

	// per-core state
	logic [cilm_pkg::TS_W-1:0] idle_total_q      [NUM_CORES];
	logic                      has_reported_q    [NUM_CORES];
	logic [cilm_pkg::TS_W-1:0] idle_start_q      [NUM_CORES];
	logic [NEST_BITS-1:0]      nest_level_q      [NUM_CORES];
	logic [cilm_pkg::TS_W-1:0] prev_idle_total_q [NUM_CORES];
	logic [cilm_pkg::TS_W-1:0] prev_query_time_q [NUM_CORES];

	// working registers
	cilm_pkg::req_item_t         item_q;
	logic [cilm_pkg::TS_W-1:0]   elapsed_q;
	logic [cilm_pkg::TS_W-1:0]   span_q;
	logic [cilm_pkg::PROD_W-1:0] rem_q;
	logic [cilm_pkg::PCT_W-1:0]  quo_q;
	logic [cilm_pkg::CNT_W-1:0]  cnt_q;
	cilm_pkg::rsp_item_t         res_q;
	cilm_pkg::rsp_item_t         rsp_q;

	logic [CORE_W-1:0]           idx;
	logic                        core_ok;
	logic [cilm_pkg::TS_W-1:0]   elapsed;
	logic [cilm_pkg::TS_W-1:0]   span;
	logic [cilm_pkg::TS_W-1:0]   span_clamped;
	logic [cilm_pkg::PROD_W-1:0] div_shifted;
	logic [cilm_pkg::PROD_W-1:0] div_bound;
	logic                        div_ge;
	logic [cilm_pkg::PCT_W-1:0]  quo_next;
	logic [cilm_pkg::PCT_W-1:0]  quo_bit;

	assign idx     = CORE_W'(item_q.core);
	assign core_ok = (32'(item_q.core) < NUM_CORES);

	assign elapsed      = item_q.now_us - prev_query_time_q[idx];
	assign span         = idle_total_q[idx] - prev_idle_total_q[idx];
	assign span_clamped = (span > elapsed) ? elapsed : span;

	// restoring divide, quotient bit cnt_q per step
	assign div_shifted = cilm_pkg::PROD_W'(elapsed_q) << cnt_q;
	assign div_bound   = cilm_pkg::PROD_W'(elapsed_q) << (4'(cnt_q) + 4'd1);
	assign div_ge      = (rem_q >= div_shifted);
	assign quo_bit     = cilm_pkg::PCT_W'(1) << cnt_q;
	assign quo_next    = div_ge ? (quo_q | quo_bit) : quo_q;

	always_comb begin
		status.is_event     = core_ok && ((item_q.action == cilm_pkg::ACT_IDLE) ||
		                                  (item_q.action == cilm_pkg::ACT_BUSY));
		status.is_query     = (item_q.action == cilm_pkg::ACT_QUERY);
		status.seen         = core_ok && has_reported_q[idx];
		status.elapsed_zero = (elapsed == '0);
		status.div_last     = (cnt_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CORES; i++) begin
				idle_total_q[i]      <= '0;
				has_reported_q[i]    <= 1'b0;
				idle_start_q[i]      <= '0;
				nest_level_q[i]      <= '0;
				prev_idle_total_q[i] <= '0;
				prev_query_time_q[i] <= '0;
			end
		end else begin
			if (cmd.do_event) begin
				if (item_q.action == cilm_pkg::ACT_IDLE) begin
					if (!has_reported_q[idx]) begin
						prev_query_time_q[idx] <= item_q.now_us;
						prev_idle_total_q[idx] <= '0;
						has_reported_q[idx]    <= 1'b1;
					end
					if (nest_level_q[idx] == '0) begin
						idle_start_q[idx] <= item_q.now_us;
					end
					if (nest_level_q[idx] != NEST_MAX) begin
						nest_level_q[idx] <= nest_level_q[idx] + NEST_ONE;
					end
				end else if (nest_level_q[idx] != '0) begin
					nest_level_q[idx] <= nest_level_q[idx] - NEST_ONE;
					if (nest_level_q[idx] == NEST_ONE) begin
						idle_total_q[idx] <= idle_total_q[idx] +
							(item_q.now_us - idle_start_q[idx]);
					end
				end
			end
			if (cmd.do_query) begin
				prev_query_time_q[idx] <= item_q.now_us;
				prev_idle_total_q[idx] <= idle_total_q[idx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= req;
		end
		if (cmd.do_query) begin
			elapsed_q          <= elapsed;
			span_q             <= span_clamped;
			res_q.load_percent <= '0;
			res_q.never_seen   <= 1'b0;
		end
		if (cmd.set_unseen) begin
			res_q.load_percent <= '0;
			res_q.never_seen   <= 1'b1;
		end
		if (cmd.load_mul) begin
			rem_q <= cilm_pkg::PROD_W'(span_q) * cilm_pkg::PROD_W'(cilm_pkg::PCT_FULL);
			quo_q <= '0;
			cnt_q <= cilm_pkg::CNT_W'(cilm_pkg::DIV_STEPS - 1);
		end
		if (cmd.div_step) begin
			if (div_ge) begin
				rem_q <= rem_q - div_shifted;
			end
			quo_q <= quo_next;
			cnt_q <= cnt_q - cilm_pkg::CNT_W'(1);
			if (cnt_q == '0) begin
				res_q.load_percent <= cilm_pkg::PCT_FULL - quo_next;
			end
		end
		if (cmd.load_out) begin
			rsp_q <= res_q;
		end
	end

	assign rsp = rsp_q;

	// span is clamped, so the remainder always fits below the next divisor step
	`CILM_ASSERT_IMP(a_div_rem_bound, cmd.div_step, rem_q < div_bound, "divide remainder out of range")
	`CILM_ASSERT_IMP(a_pct_range, cmd.load_out, res_q.load_percent <= cilm_pkg::PCT_FULL, "load above 100")

endmodule

`default_nettype wire

// ===== src/cilm_ctrl.sv =====
// Controller: sequences one item at a time and owns the result beat valid.
`default_nettype none
`include "core_idle_load_monitor_defines.svh"

module cilm_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    req_valid,
	output logic                   req_stall,
	output logic                   rsp_valid,
	input  wire                    rsp_stall,
	input  cilm_pkg::cilm_status_t status,
	output cilm_pkg::cilm_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_DIV,
		ST_DELIVER
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (status.is_event) begin
					cmd.do_event = 1'b1;
					state_d      = ST_IDLE;
				end else if (status.is_query) begin
					if (!status.seen) begin
						cmd.set_unseen = 1'b1;
						state_d        = ST_DELIVER;
					end else begin
						cmd.do_query = 1'b1;
						state_d      = status.elapsed_zero ? ST_DELIVER : ST_MUL;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_MUL: begin
				cmd.load_mul = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_DELIVER;
				end
			end
			ST_DELIVER: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`CILM_ASSERT_IMP(a_no_overwrite, cmd.load_out, out_free, "result overwritten while stalled")
	`CILM_ASSERT_IMP(a_rsp_from_deliver, $rose(rsp_valid_q), $past(state_q) == ST_DELIVER, "result beat without delivery")

endmodule

`default_nettype wire

// ===== src/core_idle_load_monitor.sv =====
// Top level of the core idle load monitor: controller plus datapath.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  req     | in        | req_valid / req_stall | action, core, now_us
//  rsp     | out       | rsp_valid / rsp_stall | load_percent, never_seen
//
// Steps: an idle/busy event is accepted, then updates its core; a query of a core
// that never reported, or one with zero elapsed time, is accepted and handed off; a
// full query runs accept, window update, multiply by 100, 7 restoring divide steps,
// hand-off.
// Reset: arst_n clears all per-core counters and the controller at once.
// Stalls: a result beat waits in the output register; the next item is taken
// meanwhile, and only a second result waits for rsp_stall to drop.
`default_nettype none

module core_idle_load_monitor #(
	parameter int NUM_CORES = cilm_pkg::NUM_CORES_DEF,
	parameter int NEST_BITS = cilm_pkg::NEST_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  cilm_pkg::req_item_t req,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output cilm_pkg::rsp_item_t rsp
);

	// command/status link between the two halves
	cilm_pkg::cilm_cmd_t    cmd;
	cilm_pkg::cilm_status_t status;

	// sequencer: one item in flight, result beat valid lives here
	cilm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// per-core idle totals, query windows and the divide unit
	cilm_dp #(
		.NUM_CORES (NUM_CORES),
		.NEST_BITS (NEST_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.status (status),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire
